/* rtl/ptw_pkg.sv */
package ptw_pkg;

    localparam int VA_W   = 64;
    localparam int PA_W   = 48;
    localparam int SF_W   = 6;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 48;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    localparam logic [IDX_W-1:0] CFG_TEN   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_LO_SF = 3'd1;
    localparam logic [IDX_W-1:0] CFG_HI_SF = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MAX   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LO_TB = 3'd4;
    localparam logic [IDX_W-1:0] CFG_HI_TB = 3'd5;

    localparam logic [1:0] LVL_0 = 2'd0;
    localparam logic [1:0] LVL_1 = 2'd1;
    localparam logic [1:0] LVL_2 = 2'd2;
    localparam logic [1:0] LVL_3 = 2'd3;

    typedef struct packed {
        logic            ten;
        logic [SF_W-1:0] lo_sf;
        logic [SF_W-1:0] hi_sf;
        logic [SF_W-1:0] max_sz;
        logic [PA_W-1:0] lo_tb;
        logic [PA_W-1:0] hi_tb;
    } t_cfg;

    typedef struct packed {
        logic            vld;
        logic [1:0]      kind;
        logic [VA_W-1:0] addr;
        logic [1:0]      level;
    } t_res;

endpackage

/* rtl/ptw_cfg.sv */
module ptw_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [ptw_pkg::IDX_W-1:0]  i_index,
    input  logic [ptw_pkg::DATA_W-1:0] i_data,
    output ptw_pkg::t_cfg              o_cfg
);
    import ptw_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ten    <= 1'b0;
            r_cfg.lo_sf  <= SF_W'(16);
            r_cfg.hi_sf  <= SF_W'(16);
            r_cfg.max_sz <= SF_W'(48);
            r_cfg.lo_tb  <= '0;
            r_cfg.hi_tb  <= '0;
        end else if (i_wr) begin
            case (i_index)
                CFG_TEN:   r_cfg.ten    <= i_data[0];
                CFG_LO_SF: r_cfg.lo_sf  <= i_data[SF_W-1:0];
                CFG_HI_SF: r_cfg.hi_sf  <= i_data[SF_W-1:0];
                CFG_MAX:   r_cfg.max_sz <= i_data[SF_W-1:0];
                CFG_LO_TB: r_cfg.lo_tb  <= i_data[PA_W-1:0];
                CFG_HI_TB: r_cfg.hi_tb  <= i_data[PA_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/ptw_step.sv */
module ptw_step (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic                     i_op,
    input  logic [ptw_pkg::VA_W-1:0] i_va,
    input  logic [ptw_pkg::VA_W-1:0] i_desc,
    input  ptw_pkg::t_cfg            i_cfg,
    output ptw_pkg::t_res            o_res
);
    import ptw_pkg::*;

    logic            r_busy;
    logic [1:0]      r_level;
    logic [PA_W-1:0] r_sva;
    logic            n_busy;
    logic [1:0]      n_level;
    logic [PA_W-1:0] n_sva;

    logic            upper;
    logic [SF_W-1:0] sf;
    logic [SF_W:0]   size_raw;
    logic [SF_W:0]   size;
    logic [1:0]      start_lvl;
    logic            too_small;
    logic [PA_W-1:0] rd_base;
    logic [1:0]      rd_lvl;
    logic [PA_W-1:0] rd_va;
    logic [8:0]      idx;
    logic [PA_W-1:0] rd_addr;
    logic [PA_W-1:0] pa;
    t_res            res;

    assign upper    = i_va[VA_W-1];
    assign sf       = upper ? i_cfg.hi_sf : i_cfg.lo_sf;
    assign size_raw = (SF_W+1)'(64) - {1'b0, sf};
    assign size     = (size_raw > {1'b0, i_cfg.max_sz}) ? {1'b0, i_cfg.max_sz} : size_raw;

    always_comb begin
        too_small = 1'b0;
        start_lvl = LVL_0;
        if (size >= (SF_W+1)'(39))      start_lvl = LVL_0;
        else if (size >= (SF_W+1)'(30)) start_lvl = LVL_1;
        else if (size >= (SF_W+1)'(21)) start_lvl = LVL_2;
        else if (size >= (SF_W+1)'(12)) start_lvl = LVL_3;
        else                            too_small = 1'b1;
    end

    // descriptor read address for either a new walk or the next level
    always_comb begin
        if (i_op) begin
            rd_base = {i_desc[PA_W-1:12], 12'b0};
            rd_lvl  = r_level + 2'd1;
            rd_va   = r_sva;
        end else begin
            rd_base = upper ? i_cfg.hi_tb : i_cfg.lo_tb;
            rd_lvl  = start_lvl;
            rd_va   = i_va[PA_W-1:0];
        end
        case (rd_lvl)
            LVL_0:   idx = rd_va[47:39];
            LVL_1:   idx = rd_va[38:30];
            LVL_2:   idx = rd_va[29:21];
            LVL_3:   idx = rd_va[20:12];
            default: idx = rd_va[47:39];
        endcase
        rd_addr = rd_base + {36'b0, idx, 3'b000};
    end

    always_comb begin
        case (r_level)
            LVL_1:   pa = {i_desc[47:30], r_sva[29:0]};
            LVL_2:   pa = {i_desc[47:21], r_sva[20:0]};
            LVL_3:   pa = {i_desc[47:12], r_sva[11:0]};
            default: pa = '0;
        endcase
    end

    always_comb begin
        n_busy    = r_busy;
        n_level   = r_level;
        n_sva     = r_sva;
        res.vld   = 1'b0;
        res.kind  = KIND_FAULT;
        res.addr  = '0;
        res.level = LVL_0;
        if (!i_op) begin
            res.vld = 1'b1;
            n_busy  = 1'b0;
            if (!i_cfg.ten) begin
                res.kind = KIND_DONE;
                res.addr = i_va;
            end else if (!too_small) begin
                n_busy    = 1'b1;
                n_level   = start_lvl;
                n_sva     = i_va[PA_W-1:0];
                res.kind  = KIND_READ;
                res.addr  = {16'b0, rd_addr};
                res.level = start_lvl;
            end
        end else if (r_busy) begin
            res.vld   = 1'b1;
            res.level = r_level;
            if (!i_desc[0]) begin
                n_busy = 1'b0;
            end else if (r_level != LVL_3 && i_desc[1]) begin
                n_level   = rd_lvl;
                res.kind  = KIND_READ;
                res.addr  = {16'b0, rd_addr};
                res.level = rd_lvl;
            end else begin
                n_busy = 1'b0;
                if (r_level != LVL_0) begin
                    res.kind = KIND_DONE;
                    res.addr = {16'b0, pa};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= LVL_0;
            r_sva   <= '0;
        end else if (i_fire) begin
            r_busy  <= n_busy;
            r_level <= n_level;
            r_sva   <= n_sva;
        end
    end

    assign o_res = res;

endmodule

/* rtl/page_table_walker_4k.sv */
// channel  | direction | handshake                | payload
// in       | in        | i_in_valid / o_in_stall  | i_op, i_virtual_address, i_descriptor
// out      | out       | o_out_valid / i_out_stall| o_kind, o_address_out, o_walk_level
// cfg      | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle while the result is not stalled; an accepted item goes to the
// input register, then through decode and address add into the result register.
// Descriptors arriving with no walk in progress give no result item.
// Synchronous active-low reset clears valids and walk state and sets config defaults.
// A stalled result holds the pipe; the input register keeps one item.
module page_table_walker_4k (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_op,
    input  logic [ptw_pkg::VA_W-1:0]   i_virtual_address,
    input  logic [ptw_pkg::VA_W-1:0]   i_descriptor,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_kind,
    output logic [ptw_pkg::VA_W-1:0]   o_address_out,
    output logic [1:0]                 o_walk_level,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ptw_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [ptw_pkg::DATA_W-1:0] i_cfg_data
);
    import ptw_pkg::*;

    logic            r_in_valid;
    logic            r_op;
    logic [VA_W-1:0] r_va;
    logic [VA_W-1:0] r_desc;
    logic            r_out_valid;
    logic [1:0]      r_kind;
    logic [VA_W-1:0] r_addr;
    logic [1:0]      r_level;
    logic            advance;
    logic            in_load;
    t_cfg            cfg;
    t_res            res;

    assign advance    = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || advance;
    assign o_in_stall = !in_load;
    assign o_cfg_ready = 1'b1;

    ptw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ptw_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (r_in_valid && advance),
        .i_op    (r_op),
        .i_va    (r_va),
        .i_desc  (r_desc),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_op   <= i_op;
            r_va   <= i_virtual_address;
            r_desc <= i_descriptor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && res.vld) begin
            r_kind  <= res.kind;
            r_addr  <= res.addr;
            r_level <= res.level;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_address_out = r_addr;
    assign o_walk_level  = r_level;

endmodule

/* rtl/ptw_chk.sv */
module ptw_chk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  logic [1:0]                 o_kind,
    input  logic [ptw_pkg::VA_W-1:0]   o_address_out,
    input  logic [1:0]                 o_walk_level
);
    import ptw_pkg::*;

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_address_out) && $stable(o_walk_level))
        else $error("stalled result changed");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == KIND_READ || o_kind == KIND_DONE
            || o_kind == KIND_FAULT))
        else $error("bad result kind");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_FAULT |-> o_address_out == '0)
        else $error("fault with non-zero address");

    a_read_48b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_READ |-> o_address_out[VA_W-1:PA_W] == '0)
        else $error("descriptor read beyond 48 bits");

endmodule

bind page_table_walker_4k ptw_chk u_ptw_chk (.*);
